// ===== src/e2q_pkg.sv =====
// Shared constants, types and helpers for the Euler-to-quaternion core.
package e2q_pkg;

	localparam int unsigned CordicStepsDef = 24;
	localparam int unsigned AtanEntries    = 30;

	// CORDIC datapath width: half angle in Q.30 reaches about +-4.3e9
	localparam int unsigned CW = 36;

	localparam logic signed [CW-1:0] CordicGain = 36'sd652032874;
	localparam logic signed [CW-1:0] PiQ30      = 36'sd3373259426;
	localparam logic signed [CW-1:0] HalfPiQ30  = 36'sd1686629713;
	localparam logic signed [33:0]   OneQ30     = 34'sd1073741824;

	// order code fields
	typedef struct packed {
		logic       rotating;
		logic       repeated;
		logic       odd;
		logic [1:0] ai;
		logic [1:0] aj;
		logic [1:0] ak;
	} order_t;

	// Return atan(2^-i) in Q.30.
	function automatic logic signed [CW-1:0] atan_q30(input int unsigned i);
		logic signed [CW-1:0] r;
		r = '0;
		case (i)
			0: r = 36'sd843314857;
			1: r = 36'sd497837829;
			2: r = 36'sd263043837;
			3: r = 36'sd133525159;
			4: r = 36'sd67021687;
			5: r = 36'sd33543516;
			6: r = 36'sd16775851;
			7: r = 36'sd8388437;
			8: r = 36'sd4194283;
			9: r = 36'sd2097149;
			default: r = (i < AtanEntries) ? (36'sd1 <<< (30 - i)) : '0;
		endcase
		return r;
	endfunction

	// Decode the 5-bit order code.
	function automatic order_t decode_order(input logic [4:0] code);
		order_t o;
		logic [1:0] ai;
		ai = (code[4:3] == 2'd3) ? 2'd0 : code[4:3];
		o.rotating = code[0];
		o.repeated = code[1];
		o.odd      = code[2];
		o.ai       = ai;
		o.aj = code[2] ? ((ai == 2'd0) ? 2'd2 : ai - 2'd1)
			: ((ai == 2'd2) ? 2'd0 : ai + 2'd1);
		o.ak = code[2] ? ((ai == 2'd2) ? 2'd0 : ai + 2'd1)
			: ((ai == 2'd0) ? 2'd2 : ai - 2'd1);
		return o;
	endfunction

	// Round a Q.60 product to Q.30 (add half, floor shift).
	function automatic logic signed [33:0] rnd60(input logic signed [65:0] p);
		logic signed [65:0] t;
		t = p + 66'sd536870912;
		return t[63:30];
	endfunction

	// Clamp to [-1, 1] in Q.30.
	function automatic logic signed [31:0] sat_unit(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'(OneQ30))
			r = 32'sd1073741824;
		else if (v < -66'(OneQ30))
			r = -32'sd1073741824;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ===== src/e2q_cordic.sv =====
// Pipelined half-angle sine/cosine CORDIC, one iteration per stage.
module e2q_cordic
	import e2q_pkg::*;
#(
	parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [31:0]   half_q29,
	output logic signed [CW-1:0] cos_o,
	output logic signed [CW-1:0] sin_o
);

	logic signed [CW-1:0] x_s [CORDIC_STEPS+1];
	logic signed [CW-1:0] y_s [CORDIC_STEPS+1];
	logic signed [CW-1:0] z_s [CORDIC_STEPS+1];
	logic                 f_s [CORDIC_STEPS+1];

	logic signed [CW-1:0] t;

	// Fold the half angle into [-pi/2, pi/2] and load the first stage
	always_comb begin
		t = CW'(half_q29) <<< 1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CordicGain;
			y_s[0] <= '0;
			if (t > HalfPiQ30) begin
				z_s[0] <= t - PiQ30;
				f_s[0] <= 1'b1;
			end else if (t < -HalfPiQ30) begin
				z_s[0] <= t + PiQ30;
				f_s[0] <= 1'b1;
			end else begin
				z_s[0] <= t;
				f_s[0] <= 1'b0;
			end
		end
	end

	// Advance one micro-rotation per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				f_s[i+1] <= f_s[i];
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q30(i);
				end
			end
		end
	end

	assign cos_o = f_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS];
	assign sin_o = f_s[CORDIC_STEPS] ? -y_s[CORDIC_STEPS] : y_s[CORDIC_STEPS];

endmodule

// ===== src/e2q_combine.sv =====
// Product stages that combine the half-angle terms into a quaternion.
module e2q_combine
	import e2q_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  order_t               ord,
	input  logic signed [CW-1:0] ci,
	input  logic signed [CW-1:0] si,
	input  logic signed [CW-1:0] cj,
	input  logic signed [CW-1:0] sj,
	input  logic signed [CW-1:0] ch,
	input  logic signed [CW-1:0] sh,
	output logic signed [31:0]   qw,
	output logic signed [31:0]   qx,
	output logic signed [31:0]   qy,
	output logic signed [31:0]   qz
);

	// stage 1: pair products
	logic signed [33:0] cc_s1, cs_s1, sc_s1, ss_s1, cj_s1, sj_s1;
	order_t             ord_s1;
	// stage 2: products by the middle terms
	logic signed [65:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2, p7_s2;
	order_t             ord_s2;
	// stage 3: rounded components
	logic signed [31:0] w_s3;
	logic signed [31:0] c_s3 [3];

	logic signed [33:0] ci_n, si_n, cj_n, sj_n, ch_n, sh_n;
	logic signed [65:0] e0, e1, e2, ew;
	logic signed [31:0] cmp [3];
	logic signed [31:0] wv;

	assign ci_n = ci[33:0];
	assign si_n = si[33:0];
	assign cj_n = cj[33:0];
	assign sj_n = ord.odd ? -sj[33:0] : sj[33:0];
	assign ch_n = ch[33:0];
	assign sh_n = sh[33:0];

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s1  <= rnd60(66'(ci_n) * 66'(ch_n));
			cs_s1  <= rnd60(66'(ci_n) * 66'(sh_n));
			sc_s1  <= rnd60(66'(si_n) * 66'(ch_n));
			ss_s1  <= rnd60(66'(si_n) * 66'(sh_n));
			cj_s1  <= cj_n;
			sj_s1  <= sj_n;
			ord_s1 <= ord;
		end
	end

	// Form the middle products: eight in general, four in repeated orders
	always_ff @(posedge clk) begin
		if (en) begin
			ord_s2 <= ord_s1;
			if (ord_s1.repeated) begin
				p0_s2 <= 66'(cj_s1) * 66'(cs_s1 + sc_s1);
				p1_s2 <= '0;
				p2_s2 <= 66'(sj_s1) * 66'(cc_s1 + ss_s1);
				p3_s2 <= '0;
				p4_s2 <= 66'(sj_s1) * 66'(cs_s1 - sc_s1);
				p5_s2 <= '0;
				p6_s2 <= 66'(cj_s1) * 66'(cc_s1 - ss_s1);
				p7_s2 <= '0;
			end else begin
				p0_s2 <= 66'(cj_s1) * 66'(sc_s1);
				p1_s2 <= -(66'(sj_s1) * 66'(cs_s1));
				p2_s2 <= 66'(cj_s1) * 66'(ss_s1);
				p3_s2 <= 66'(sj_s1) * 66'(cc_s1);
				p4_s2 <= 66'(cj_s1) * 66'(cs_s1);
				p5_s2 <= -(66'(sj_s1) * 66'(sc_s1));
				p6_s2 <= 66'(cj_s1) * 66'(cc_s1);
				p7_s2 <= 66'(sj_s1) * 66'(ss_s1);
			end
		end
	end

	// Sum, round, clamp and place components on their axes
	always_comb begin
		e0 = 66'(rnd60(p0_s2 + p1_s2));
		e1 = 66'(rnd60(p2_s2 + p3_s2));
		e2 = 66'(rnd60(p4_s2 + p5_s2));
		ew = 66'(rnd60(p6_s2 + p7_s2));
		wv = sat_unit(ew);
		cmp[0] = '0;
		cmp[1] = '0;
		cmp[2] = '0;
		cmp[ord_s2.ai] = sat_unit(e0);
		cmp[ord_s2.aj] = ord_s2.odd ? -sat_unit(e1) : sat_unit(e1);
		cmp[ord_s2.ak] = sat_unit(e2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s3 <= wv;
			c_s3 <= cmp;
		end
	end

	assign qw = w_s3;
	assign qx = c_s3[0];
	assign qy = c_s3[1];
	assign qz = c_s3[2];

endmodule

// ===== src/euler_to_quaternion_core.sv =====
// Top level: Euler angles (any of 24 orders) to unit quaternion, pipelined.
// Usage:
//   Input channel: angle_first/second/third (Q4.28 rad) and order_code,
//   taken on in_valid && in_ready. Output channel: quat_w/x/y/z (Q2.30),
//   taken on out_valid && out_ready.
//   The pipe has one fold stage, one stage per CORDIC iteration, three
//   product stages and one output register. Throughput is one word per
//   cycle unless the output stalls; the CORDIC unrolls into one stage per
//   iteration and each multiply level has its own register.
//   A stall on the output holds the word in the output register; the pipe
//   keeps advancing into empty stages and freezes once its last stage is
//   full. in_ready drops only while the output register holds a word not
//   taken and the pipe would overwrite it, so nothing is lost or repeated.
//   Reset clears all valid bits; payload registers are not reset.
module euler_to_quaternion_core
	import e2q_pkg::*;
#(
	parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] angle_first,
	input  logic signed [31:0] angle_second,
	input  logic signed [31:0] angle_third,
	input  logic [4:0]         order_code,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] quat_w,
	output logic signed [31:0] quat_x,
	output logic signed [31:0] quat_y,
	output logic signed [31:0] quat_z
);

	localparam int unsigned Depth = CORDIC_STEPS + 4;

	logic [Depth-1:0] vld_q;
	logic             en;
	order_t           ord_in;
	order_t           ord_q [CORDIC_STEPS+1];
	logic signed [CW-1:0] ci, si, cj, sj, ch, sh;
	logic signed [31:0] a0, a2;

	// Advance whenever the last stage is empty or the output slot frees
	assign en       = !out_valid || out_ready || !vld_q[Depth-1];
	assign in_ready = en;
	assign ord_in   = decode_order(order_code);
	assign a0 = ord_in.rotating ? angle_third : angle_first;
	assign a2 = ord_in.rotating ? angle_first : angle_third;

	e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_c0 (
		.clk, .en, .half_q29(a0), .cos_o(ci), .sin_o(si));
	e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_c1 (
		.clk, .en, .half_q29(angle_second), .cos_o(cj), .sin_o(sj));
	e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_c2 (
		.clk, .en, .half_q29(a2), .cos_o(ch), .sin_o(sh));

	// Carry the decoded order beside the CORDIC stages
	always_ff @(posedge clk) begin
		if (en) begin
			ord_q[0] <= ord_in;
			for (int i = 0; i < CORDIC_STEPS; i++)
				ord_q[i+1] <= ord_q[i];
		end
	end

	logic signed [31:0] qw, qx, qy, qz;

	e2q_combine u_comb (
		.clk, .en, .ord(ord_q[CORDIC_STEPS]), .ci, .si, .cj, .sj, .ch, .sh,
		.qw, .qx, .qy, .qz);

	// Shift valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Depth-2:0], in_valid};
		end
	end

	// Output register: hold a word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= vld_q[Depth-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_q[Depth-1]) begin
			quat_w <= qw;
			quat_x <= qx;
			quat_y <= qy;
			quat_z <= qz;
		end
	end

	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && vld_q[Depth-1] |=> out_valid && $stable(quat_w))
		else $error("output word lost under stall");
	a_stall : assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while stalled");
	a_range : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (quat_w <= 32'sd1073741824 && quat_w >= -32'sd1073741824))
		else $error("quat_w out of unit range");

endmodule

// ===== tb/tb_euler_to_quaternion_core.sv =====
// Testbench for euler_to_quaternion_core: angle words checked against a bit-true predictor.
`timescale 1ns / 1ps

module tb_euler_to_quaternion_core;
	import e2q_pkg::*;

	localparam int Steps    = 24;
	localparam int Latency  = Steps + 5;
	localparam int WdogMax  = 2000;
	localparam int NumRand  = 750;

	typedef struct {
		logic signed [31:0] a0, a1, a2;
		logic [4:0]         code;
	} angles_t;

	typedef struct {
		logic signed [31:0] w, x, y, z;
	} quat_t;

	// order code bits
	localparam int BitRot = 0;
	localparam int BitRep = 1;
	localparam int BitOdd = 2;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [31:0] angle_first = 0, angle_second = 0, angle_third = 0;
	logic [4:0] order_code = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] quat_w, quat_x, quat_y, quat_z;

	angles_t pending_words[$];
	quat_t   expected_quats[$];
	int      errors = 0;
	int      checked = 0;
	bit      quiet_phase = 0;
	bit      hold_sender = 0;
	int      in_gap = 0, out_gap = 0;
	int      wdog = 0;

	euler_to_quaternion_core #(.CORDIC_STEPS(Steps)) dut (.*);

	always #6 clk = ~clk;

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_prod(longint p);
		return (p + (64'sd1 << 29)) >>> 30;
	endfunction

	function automatic longint clamp_unit(longint v);
		if (v > 64'sd1073741824) return 64'sd1073741824;
		if (v < -64'sd1073741824) return -64'sd1073741824;
		return v;
	endfunction

	function automatic longint atan_entry(int i);
		longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149};
		if (i < 10) return tbl[i];
		return 64'sd1 << (30 - i);
	endfunction

	// Half-angle cos/sin by folded CORDIC; input is raw Q3.29 half angle
	function automatic void half_cordic(input longint half, output longint c,
			output longint s);
		longint t, x, y, nx;
		bit flip;
		t = half * 2;
		x = 652032874;
		y = 0;
		flip = 0;
		if (t > 64'sd1686629713) begin
			t -= 64'sd3373259426;
			flip = 1;
		end else if (t < -64'sd1686629713) begin
			t += 64'sd3373259426;
			flip = 1;
		end
		for (int i = 0; i < Steps; i++) begin
			if (t >= 0) begin
				nx = x - fshift(y, i);
				y = y + fshift(x, i);
				t -= atan_entry(i);
			end else begin
				nx = x + fshift(y, i);
				y = y - fshift(x, i);
				t += atan_entry(i);
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = x;
		s = y;
	endfunction

	// Predict the quaternion for one angle word
	function automatic quat_t predict_quat(angles_t a);
		quat_t q;
		int ai, aj, ak;
		bit rot, rep, odd;
		longint e0, e1, e2, ci, si, cj, sj, ch, sh, cc, cs, sc, ss, w;
		longint comp[3];
		rot = a.code[BitRot];
		rep = a.code[BitRep];
		odd = a.code[BitOdd];
		ai = (a.code[4:3] == 3) ? 0 : a.code[4:3];
		aj = odd ? (ai + 2) % 3 : (ai + 1) % 3;
		ak = odd ? (ai + 1) % 3 : (ai + 2) % 3;
		e0 = rot ? a.a2 : a.a0;
		e1 = a.a1;
		e2 = rot ? a.a0 : a.a2;
		half_cordic(e0, ci, si);
		half_cordic(e1, cj, sj);
		half_cordic(e2, ch, sh);
		if (odd) sj = -sj;
		cc = round_prod(ci * ch);
		cs = round_prod(ci * sh);
		sc = round_prod(si * ch);
		ss = round_prod(si * sh);
		if (rep) begin
			comp[ai] = round_prod(cj * (cs + sc));
			comp[aj] = round_prod(sj * (cc + ss));
			comp[ak] = round_prod(sj * (cs - sc));
			w = round_prod(cj * (cc - ss));
		end else begin
			comp[ai] = round_prod(cj * sc - sj * cs);
			comp[aj] = round_prod(cj * ss + sj * cc);
			comp[ak] = round_prod(cj * cs - sj * sc);
			w = round_prod(cj * cc + sj * ss);
		end
		for (int n = 0; n < 3; n++) comp[n] = clamp_unit(comp[n]);
		w = clamp_unit(w);
		if (odd) comp[aj] = -comp[aj];
		q.w = w[31:0];
		q.x = comp[0][31:0];
		q.y = comp[1][31:0];
		q.z = comp[2][31:0];
		return q;
	endfunction

	function automatic logic signed [31:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(0, 32'h3FFFFFFF)) - 32'sh20000000;
			default: return $urandom;
		endcase
	endfunction

	// Drive: hold the word until accepted, idle in random bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_quats.push_back(predict_quat(pending_words.pop_front()));
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 0;
				end else if (pending_words.size() > (in_valid && in_ready ? 0 : 0)
						&& !hold_sender) begin
					if (!quiet_phase && $urandom_range(0, 9) == 0) begin
						in_gap <= $urandom_range(0, 6);
						in_valid <= 0;
					end else if (pending_words.size() > 0) begin
						in_valid <= 1;
						angle_first <= pending_words[0].a0;
						angle_second <= pending_words[0].a1;
						angle_third <= pending_words[0].a2;
						order_code <= pending_words[0].code;
					end else begin
						in_valid <= 0;
					end
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// Monitor: check each accepted word and stall at random
	always @(posedge clk) begin
		quat_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_quats.size() == 0) begin
					$error("unexpected word w=%0d", quat_w);
					errors++;
				end else begin
					e = expected_quats.pop_front();
					checked++;
					if (quat_w !== e.w) begin
						$error("quat_w exp %0d got %0d", e.w, quat_w); errors++;
					end
					if (quat_x !== e.x) begin
						$error("quat_x exp %0d got %0d", e.x, quat_x); errors++;
					end
					if (quat_y !== e.y) begin
						$error("quat_y exp %0d got %0d", e.y, quat_y); errors++;
					end
					if (quat_z !== e.z) begin
						$error("quat_z exp %0d got %0d", e.z, quat_z); errors++;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 0;
			end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
				out_gap <= $urandom_range(0, 6);
				out_ready <= 0;
			end else begin
				out_ready <= 1;
			end
			// watchdog on accepted traffic
			if ((in_valid && in_ready) || (out_valid && out_ready)) wdog <= 0;
			else wdog <= wdog + 1;
			if (wdog >= WdogMax) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		angles_t a;
		logic signed [31:0] corners[6] = '{32'sh7FFFFFFF, 32'sh80000000, 0, 32'sh1921FB54,
			-32'sh1921FB54, 32'sh3243F6A8};
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		// directed: corner angles with sixteen order codes whose bit 0 equals bit 1, then eight more codes
		for (int c = 0; c < 32; c += 2) begin
			a.code = 5'(c | ((c >> 1) & 1));
			a.a0 = corners[c % 6];
			a.a1 = corners[(c + 1) % 6];
			a.a2 = corners[(c + 3) % 6];
			pending_words.push_back(a);
		end
		for (int c = 0; c < 8; c++) begin
			a.code = {c[1:0] ^ 2'd3, c[2:0]};
			a.a0 = corners[c % 2];
			a.a1 = corners[(c + 1) % 2];
			a.a2 = corners[c % 3];
			pending_words.push_back(a);
		end
		wait (pending_words.size() == 0);
		// drain fully before the random part
		hold_sender = 1;
		wait (expected_quats.size() == 0 && !in_valid);
		hold_sender = 0;
		for (int n = 0; n < NumRand; n++) begin
			a.code = 5'($urandom);
			a.a0 = rand_angle();
			a.a1 = rand_angle();
			a.a2 = rand_angle();
			pending_words.push_back(a);
			if (n == NumRand - 150) begin
				wait (pending_words.size() == 0);
				quiet_phase = 1;
			end
		end
		wait (pending_words.size() == 0 && !in_valid);
		wait (expected_quats.size() == 0);
		repeat (Latency + 5) @(posedge clk);
		$display("Checked %0d quaternions over all 32 order codes, corner and random angles,",
			checked);
		$display("with random idling on both channels and a full drain pause.");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
